### hw/rtl/mpk_pkg.sv
// Shared types and constants of the Morse paddle keyer and decoder.
package mpk_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam int TIMER_BITS_DEFAULT  = 16;

    localparam int SPEED_W     = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam int DOT_NUMERATOR = 1200;
    localparam int DIV_STEPS     = $clog2(DOT_NUMERATOR + 1);
    localparam int DOT_W         = DIV_STEPS;
    localparam int DOT3_W        = DOT_W + 1;

    localparam logic [SPEED_W-1:0] SPEED_RESET   = SPEED_W'(20);
    localparam logic [7:0]         PATTERN_EMPTY = 8'h80;
    localparam int                 CHAR_BASE     = 44;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_TABLE_WR = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_WPM     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_ENTRIES = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic       dit_paddle;
        logic       dah_paddle;
        logic       straight_key;
        logic [5:0] table_index;
        logic [7:0] table_value;
    } cmd_t;

    typedef struct packed {
        logic       key_out;
        logic       char_valid;
        logic [6:0] char_code;
    } rsp_t;

endpackage

### hw/rtl/morse_paddle_keyer_decoder.sv
// Top level of the Morse paddle keyer with character decoder.
// The result of a timer tick or a table write is registered and appears in the cycle after the
// transfer, except for a tick that ends a character: that one first walks the code table through
// its single read port, one entry a cycle. The dot length 1200 / speed_wpm comes from a
// bit-serial divider that runs after reset and after each write of speed_wpm; no command is
// taken while it runs. A result waiting in the output register does not stop the next command
// from being taken, as long as the consumer is not stalling it.
module morse_paddle_keyer_decoder #(
    parameter int TABLE_DEPTH = mpk_pkg::TABLE_DEPTH_DEFAULT,
    parameter int TIMER_BITS  = mpk_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mpk_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpk_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  mpk_pkg::cmd_t                       cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output mpk_pkg::rsp_t                       rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = mpk_pkg::DOT_W;
    localparam int D3W = mpk_pkg::DOT3_W;
    localparam int SW = mpk_pkg::SPEED_W;
    localparam int DCW = $clog2(mpk_pkg::DIV_STEPS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SCALE,
        ST_IDLE,
        ST_SEARCH
    } seq_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND_DIT,
        PH_SEND_DAH,
        PH_WAIT_DIT,
        PH_WAIT_DAH,
        PH_PAUSE,
        PH_CHAR_OUT
    } phase_t;

    seq_t   state_reg, state_next;
    phase_t phase_reg, phase_next, t_phase;

    logic [SW-1:0] speed_wpm_reg, speed_wpm_next;
    logic          manual_mode_reg, manual_mode_next;
    logic [6:0]    table_entries_reg, table_entries_next;

    logic [DW-1:0]  div_num_reg, div_num_next;
    logic [SW-1:0]  div_rem_reg, div_rem_next;
    logic [SW-1:0]  div_den_reg, div_den_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [SW:0]    div_trial;
    logic           div_qbit;

    logic [DW-1:0]  dot_reg, dot_next;
    logic [D3W-1:0] dot2_reg, dot2_next;
    logic [D3W-1:0] dot3_reg, dot3_next;

    logic [TIMER_BITS-1:0] element_timer_reg, element_timer_next, t_element_timer, et_inc;
    logic [TIMER_BITS-1:0] gap_timer_reg, gap_timer_next, t_gap_timer;
    logic [7:0]            pattern_reg, pattern_next, t_pattern;
    logic                  key_line_reg, key_line_next, t_key_line;
    logic                  t_start_search;
    logic [D3W-1:0]        wait_limit;

    logic [7:0]    search_pat_reg, search_pat_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0] entries_lim;
    logic          search_hit, search_miss, rd_en;
    logic [8:0]    code_sum;

    logic          rsp_valid_reg, rsp_valid_next;
    mpk_pkg::rsp_t rsp_reg, rsp_next;

    logic          cmd_fire, out_free, tbl_we;

    logic [7:0] code_table [TABLE_DEPTH];
    logic [7:0] rd_data_reg;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) && out_free);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign tbl_we = cmd_fire && (cmd.opcode == mpk_pkg::OP_TABLE_WR)
                    && (32'(cmd.table_index) < 32'(TABLE_DEPTH));

    assign entries_lim = (32'(table_entries_reg) > 32'(TABLE_DEPTH))
                         ? CW'(TABLE_DEPTH) : CW'(table_entries_reg);
    assign search_hit  = cmp_valid_reg && (rd_data_reg == search_pat_reg);
    assign search_miss = !cmp_valid_reg && (issue_cnt_reg >= entries_lim);
    assign rd_en       = (state_reg == ST_SEARCH) && !search_hit && !search_miss
                         && (issue_cnt_reg < entries_lim);
    assign code_sum    = 9'(cmp_idx_reg) + 9'(mpk_pkg::CHAR_BASE);

    assign div_trial = {div_rem_reg, div_num_reg[DW-1]};
    assign div_qbit  = (div_trial >= {1'b0, div_den_reg});

    assign et_inc     = element_timer_reg + TIMER_BITS'(1);
    assign wait_limit = (phase_reg == PH_WAIT_DIT) ? D3W'(dot_reg) : dot3_reg;

    // Keyer step for one timer tick.
    always_comb
    begin
        t_phase         = phase_reg;
        t_element_timer = et_inc;
        t_gap_timer     = gap_timer_reg;
        t_pattern       = pattern_reg;
        t_key_line      = key_line_reg;
        t_start_search  = 1'b0;
        if (manual_mode_reg)
        begin
            t_key_line = cmd.straight_key;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (cmd.dit_paddle)
                    begin
                        t_phase = PH_SEND_DIT;
                    end
                    else if (cmd.dah_paddle)
                    begin
                        t_phase = PH_SEND_DAH;
                    end
                    t_gap_timer = gap_timer_reg + TIMER_BITS'(1);
                    if (32'(gap_timer_reg) > 32'(dot2_reg))
                    begin
                        t_phase = PH_CHAR_OUT;
                    end
                end
                PH_SEND_DIT:
                begin
                    t_element_timer = '0;
                    t_key_line      = 1'b1;
                    t_phase         = PH_WAIT_DIT;
                    t_pattern       = {1'b0, pattern_reg[7:1]};
                end
                PH_SEND_DAH:
                begin
                    t_element_timer = '0;
                    t_key_line      = 1'b1;
                    t_phase         = PH_WAIT_DAH;
                    t_pattern       = {1'b1, pattern_reg[7:1]};
                end
                PH_WAIT_DIT, PH_WAIT_DAH:
                begin
                    if (32'(et_inc) > 32'(wait_limit))
                    begin
                        t_key_line      = 1'b0;
                        t_element_timer = '0;
                        t_phase         = PH_PAUSE;
                    end
                end
                PH_PAUSE:
                begin
                    if (32'(et_inc) > 32'(dot_reg))
                    begin
                        t_phase = PH_IDLE;
                    end
                    t_gap_timer = '0;
                end
                PH_CHAR_OUT:
                begin
                    t_gap_timer = '0;
                    if (pattern_reg != mpk_pkg::PATTERN_EMPTY)
                    begin
                        t_pattern      = mpk_pkg::PATTERN_EMPTY;
                        t_start_search = (entries_lim != '0);
                    end
                    t_phase = PH_IDLE;
                end
                default:
                begin
                    t_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        speed_wpm_next     = speed_wpm_reg;
        manual_mode_next   = manual_mode_reg;
        table_entries_next = table_entries_reg;
        div_num_next       = div_num_reg;
        div_rem_next       = div_rem_reg;
        div_den_next       = div_den_reg;
        div_cnt_next       = div_cnt_reg;
        dot_next           = dot_reg;
        dot2_next          = dot2_reg;
        dot3_next          = dot3_reg;
        phase_next         = phase_reg;
        element_timer_next = element_timer_reg;
        gap_timer_next     = gap_timer_reg;
        pattern_next       = pattern_reg;
        key_line_next      = key_line_reg;
        search_pat_next    = search_pat_reg;
        issue_cnt_next     = issue_cnt_reg;
        cmp_idx_next       = cmp_idx_reg;
        cmp_valid_next     = cmp_valid_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        rsp_next           = rsp_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                div_num_next = DW'(mpk_pkg::DOT_NUMERATOR);
                div_rem_next = '0;
                div_den_next = (speed_wpm_reg == '0) ? SW'(1) : speed_wpm_reg;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                div_rem_next = div_qbit ? SW'(div_trial - {1'b0, div_den_reg})
                                        : SW'(div_trial);
                div_num_next = {div_num_reg[DW-2:0], div_qbit};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(mpk_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                dot_next   = div_num_reg;
                dot2_next  = {div_num_reg, 1'b0};
                dot3_next  = D3W'(div_num_reg) + {div_num_reg, 1'b0};
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.opcode == mpk_pkg::OP_TICK)
                    begin
                        phase_next         = t_phase;
                        element_timer_next = t_element_timer;
                        gap_timer_next     = t_gap_timer;
                        pattern_next       = t_pattern;
                        key_line_next      = t_key_line;
                    end
                    if ((cmd.opcode == mpk_pkg::OP_TICK) && t_start_search)
                    begin
                        search_pat_next = pattern_reg;
                        issue_cnt_next  = '0;
                        cmp_valid_next  = 1'b0;
                        state_next      = ST_SEARCH;
                    end
                    else
                    begin
                        rsp_valid_next     = 1'b1;
                        rsp_next.key_out   = (cmd.opcode == mpk_pkg::OP_TICK)
                                             ? t_key_line : key_line_reg;
                        rsp_next.char_valid = 1'b0;
                        rsp_next.char_code  = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (search_hit || search_miss)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.key_out    = key_line_reg;
                        rsp_next.char_valid = search_hit;
                        rsp_next.char_code  = search_hit ? code_sum[6:0] : 7'd0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    cmp_valid_next = rd_en;
                    cmp_idx_next   = IW'(issue_cnt_reg);
                    if (rd_en)
                    begin
                        issue_cnt_next = issue_cnt_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                mpk_pkg::CFG_SPEED_WPM:
                begin
                    speed_wpm_next = SW'(cfg_data);
                    state_next     = ST_LOAD;
                end
                mpk_pkg::CFG_MANUAL_MODE:
                begin
                    manual_mode_next = cfg_data[0];
                end
                mpk_pkg::CFG_TABLE_ENTRIES:
                begin
                    table_entries_next = cfg_data[6:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            speed_wpm_reg     <= mpk_pkg::SPEED_RESET;
            manual_mode_reg   <= 1'b0;
            table_entries_reg <= '0;
            div_num_reg       <= '0;
            div_rem_reg       <= '0;
            div_den_reg       <= '0;
            div_cnt_reg       <= '0;
            dot_reg           <= '0;
            dot2_reg          <= '0;
            dot3_reg          <= '0;
            phase_reg         <= PH_IDLE;
            element_timer_reg <= '0;
            gap_timer_reg     <= '0;
            pattern_reg       <= mpk_pkg::PATTERN_EMPTY;
            key_line_reg      <= 1'b0;
            search_pat_reg    <= '0;
            issue_cnt_reg     <= '0;
            cmp_idx_reg       <= '0;
            cmp_valid_reg     <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            rsp_reg           <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            speed_wpm_reg     <= speed_wpm_next;
            manual_mode_reg   <= manual_mode_next;
            table_entries_reg <= table_entries_next;
            div_num_reg       <= div_num_next;
            div_rem_reg       <= div_rem_next;
            div_den_reg       <= div_den_next;
            div_cnt_reg       <= div_cnt_next;
            dot_reg           <= dot_next;
            dot2_reg          <= dot2_next;
            dot3_reg          <= dot3_next;
            phase_reg         <= phase_next;
            element_timer_reg <= element_timer_next;
            gap_timer_reg     <= gap_timer_next;
            pattern_reg       <= pattern_next;
            key_line_reg      <= key_line_next;
            search_pat_reg    <= search_pat_next;
            issue_cnt_reg     <= issue_cnt_next;
            cmp_idx_reg       <= cmp_idx_next;
            cmp_valid_reg     <= cmp_valid_next;
            rsp_valid_reg     <= rsp_valid_next;
            rsp_reg           <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            code_table[IW'(cmd.table_index)] <= cmd.table_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= code_table[IW'(issue_cnt_reg)];
        end
    end

endmodule

### hw/rtl/mpk_checker.sv
// Port-level checker for the Morse keyer and decoder, with its bind statement.
module mpk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [mpk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic                            cmd_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input mpk_pkg::rsp_t                   rsp
);

    // A result that carries no character carries no code.
    a_code_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.char_valid |-> rsp.char_code == 7'd0)
        else $error("character code set without a decoded character");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // With the output register full and stalled, no command may be transferred.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> cmd_stall)
        else $error("command transferred while the result register was blocked");

    // A new speed restarts the dot-length division, which holds off commands.
    a_speed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == mpk_pkg::CFG_SPEED_WPM |=> cmd_stall)
        else $error("command accepted during dot-length division");

endmodule

bind morse_paddle_keyer_decoder mpk_checker u_mpk_checker (.*);
